>>> rtl/core/fpalu_pkg.sv
// ----------------------------------------------------------------------------
// fpalu_pkg
// Shared types and constants for the signed fixed-point arithmetic unit.
// ----------------------------------------------------------------------------
package fpalu_pkg;

	// port field widths
	localparam int FIELD_WIDTH = 32;
	localparam int OP_WIDTH    = 4;

	// defaults for the top level parameters
	localparam int DEF_FRAC_BITS  = 8;
	localparam int DEF_DATA_WIDTH = 32;

	// operation codes
	typedef enum logic [OP_WIDTH-1:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_EQ       = 4'd4,
		OP_NE       = 4'd5,
		OP_LT       = 4'd6,
		OP_GT       = 4'd7,
		OP_LE       = 4'd8,
		OP_GE       = 4'd9,
		OP_MIN      = 4'd10,
		OP_MAX      = 4'd11,
		OP_INC      = 4'd12,
		OP_DEC      = 4'd13,
		OP_FROM_INT = 4'd14,
		OP_TO_INT   = 4'd15
	} op_t;

endpackage

>>> rtl/core/fixed_point_alu_top.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_top
// Pipelined signed fixed-point ALU: add, sub, mul, div, compare, min/max,
// inc/dec and integer conversions on DATA_WIDTH-bit raw values.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_ready carries operation, operand_a, operand_b
//   output channel: out_valid/out_ready carries result_value, compare_true
//   and divide_by_zero, one result per input transaction, in order
//   throughput: one transaction per cycle, every operation, while the pipeline is not frozen by a stall
//   path: every operation takes the same path
//   the depth is set by the restoring divider, which resolves one quotient
//   bit per stage over DATA_WIDTH + FRAC_BITS stages; the multiplier owns
//   one stage and the product shift the next
//   reset: all valid bits clear, in_ready comes up high, no result pending
//   stall: when out_ready is low the result holds in the output register,
//   one more result moves into a skid register, and only then does the
//   whole pipeline freeze and drop in_ready; nothing is lost or repeated
// ----------------------------------------------------------------------------
module fixed_point_alu_top #(
	parameter int FRAC_BITS  = fpalu_pkg::DEF_FRAC_BITS,
	parameter int DATA_WIDTH = fpalu_pkg::DEF_DATA_WIDTH
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	output logic                                        in_ready,
	input  fpalu_pkg::op_t                              operation,
	input  logic signed [fpalu_pkg::FIELD_WIDTH-1:0]    operand_a,
	input  logic signed [fpalu_pkg::FIELD_WIDTH-1:0]    operand_b,
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output logic signed [fpalu_pkg::FIELD_WIDTH-1:0]    result_value,
	output logic                                        compare_true,
	output logic                                        divide_by_zero
);
	import fpalu_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int QW = DATA_WIDTH + FRAC_BITS;
	localparam int PW = 2 * DATA_WIDTH;

	// pipeline advance: frozen only while the skid register is occupied
	logic adv;
	logic skid_valid_q;
	assign adv      = !skid_valid_q;
	assign in_ready = adv;

	// stage 1: register operands, narrowed to DATA_WIDTH
	logic                 valid_s1;
	op_t                  op_s1;
	logic signed [DW-1:0] a_s1, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= operation;
			a_s1  <= operand_a[DW-1:0];
			b_s1  <= operand_b[DW-1:0];
		end
	end

	// stage 2: multiplier, simple ops, compares, divider operand magnitudes
	logic                 valid_s2;
	op_t                  op_s2;
	logic signed [PW-1:0] prod_s2;
	logic        [DW-1:0] simple_s2;
	logic                 cmp_s2, dz_s2, neg_s2;
	logic        [DW-1:0] amag_s2, bmag_s2;

	logic        [DW-1:0] simple_c;
	logic                 cmp_c, lt_c, eq_c;

	always_comb begin
		lt_c     = a_s1 < b_s1;
		eq_c     = a_s1 == b_s1;
		simple_c = '0;
		cmp_c    = 1'b0;
		case (op_s1)
			OP_ADD:      simple_c = DW'(a_s1 + b_s1);
			OP_SUB:      simple_c = DW'(a_s1 - b_s1);
			OP_EQ:       cmp_c = eq_c;
			OP_NE:       cmp_c = !eq_c;
			OP_LT:       cmp_c = lt_c;
			OP_GT:       cmp_c = !lt_c && !eq_c;
			OP_LE:       cmp_c = lt_c || eq_c;
			OP_GE:       cmp_c = !lt_c;
			OP_MIN:      simple_c = lt_c ? a_s1 : b_s1;
			OP_MAX:      simple_c = (!lt_c && !eq_c) ? a_s1 : b_s1;
			OP_INC:      simple_c = DW'(a_s1 + 1);
			OP_DEC:      simple_c = DW'(a_s1 - 1);
			OP_FROM_INT: simple_c = DW'(a_s1 <<< FRAC_BITS);
			OP_TO_INT:   simple_c = DW'(a_s1 >>> FRAC_BITS);
			default:     simple_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2     <= op_s1;
			prod_s2   <= PW'(a_s1) * PW'(b_s1);
			simple_s2 <= simple_c;
			cmp_s2    <= cmp_c;
			dz_s2     <= (op_s1 == OP_DIV) && (b_s1 == '0);
			neg_s2    <= a_s1[DW-1] ^ b_s1[DW-1];
			amag_s2   <= a_s1[DW-1] ? DW'(-a_s1) : a_s1;
			bmag_s2   <= b_s1[DW-1] ? DW'(-b_s1) : b_s1;
		end
	end

	// divider stages: index 0 is stage 3 (product shift, dividend setup)
	logic          valid_sd [0:QW];
	op_t           op_sd    [0:QW];
	logic [DW-1:0] res_sd   [0:QW];
	logic          cmp_sd   [0:QW];
	logic          dz_sd    [0:QW];
	logic          neg_sd   [0:QW];
	logic [DW-1:0] rem_sd   [0:QW];
	logic [QW-1:0] quo_sd   [0:QW];
	logic [DW-1:0] dsr_sd   [0:QW];

	logic signed [PW-1:0] prod_shift_c;
	assign prod_shift_c = prod_s2 >>> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sd[0] <= 1'b0;
		end else if (adv) begin
			valid_sd[0] <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_sd[0]  <= op_s2;
			res_sd[0] <= (op_s2 == OP_MUL) ? prod_shift_c[DW-1:0] : simple_s2;
			cmp_sd[0] <= cmp_s2;
			dz_sd[0]  <= dz_s2;
			neg_sd[0] <= neg_s2;
			rem_sd[0] <= '0;
			quo_sd[0] <= QW'(amag_s2) << FRAC_BITS;
			dsr_sd[0] <= bmag_s2;
		end
	end

	// one restoring division step per stage, dividend bits shift out at the top
	// while quotient bits shift in at the bottom
	genvar k;
	generate
		for (k = 0; k < QW; k++) begin : g_div
			logic [DW:0]   trial;
			logic          ge;
			logic [DW:0]   diff;

			assign trial = {rem_sd[k], quo_sd[k][QW-1]};
			assign ge    = trial >= {1'b0, dsr_sd[k]};
			assign diff  = trial - {1'b0, dsr_sd[k]};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_sd[k+1] <= 1'b0;
				end else if (adv) begin
					valid_sd[k+1] <= valid_sd[k];
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					op_sd[k+1]  <= op_sd[k];
					res_sd[k+1] <= res_sd[k];
					cmp_sd[k+1] <= cmp_sd[k];
					dz_sd[k+1]  <= dz_sd[k];
					neg_sd[k+1] <= neg_sd[k];
					rem_sd[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
					quo_sd[k+1] <= {quo_sd[k][QW-2:0], ge};
					dsr_sd[k+1] <= dsr_sd[k];
				end
			end
		end
	endgenerate

	// final select: quotient sign fix and widening to the port
	logic [QW-1:0]              quo_fix_c;
	logic signed [DW-1:0]       fin_res_c;
	logic [FIELD_WIDTH-1:0]     fin_wide_c;
	logic                       incoming;

	always_comb begin
		quo_fix_c = neg_sd[QW] ? QW'(-quo_sd[QW]) : quo_sd[QW];
		if (op_sd[QW] == OP_DIV) begin
			fin_res_c = dz_sd[QW] ? '0 : quo_fix_c[DW-1:0];
		end else begin
			fin_res_c = res_sd[QW];
		end
		fin_wide_c = FIELD_WIDTH'(fin_res_c);
	end

	assign incoming = valid_sd[QW] && adv;

	// output register with a skid register behind it
	logic                   out_valid_q;
	logic [FIELD_WIDTH-1:0] res_q, skid_res_q;
	logic                   cmp_q, dz_q, skid_cmp_q, skid_dz_q;
	logic                   out_take;

	assign out_take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q  <= skid_valid_q || incoming;
			skid_valid_q <= 1'b0;
		end else if (incoming) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take) begin
			if (skid_valid_q) begin
				res_q <= skid_res_q;
				cmp_q <= skid_cmp_q;
				dz_q  <= skid_dz_q;
			end else begin
				res_q <= fin_wide_c;
				cmp_q <= cmp_sd[QW];
				dz_q  <= dz_sd[QW];
			end
		end else if (incoming) begin
			skid_res_q <= fin_wide_c;
			skid_cmp_q <= cmp_sd[QW];
			skid_dz_q  <= dz_sd[QW];
		end
	end

	assign out_valid      = out_valid_q;
	assign result_value   = res_q;
	assign compare_true   = cmp_q;
	assign divide_by_zero = dz_q;

`ifndef NO_ASSERTIONS
	// skid only fills behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register valid without output valid");

	// compare and divide-by-zero flags are exclusive
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && cmp_q |-> !dz_q)
		else $error("compare and divide-by-zero both set");

	// divide by zero yields zero
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && dz_q |-> res_q == '0)
		else $error("divide by zero with nonzero result");

	// a frozen pipeline keeps its first stage
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("stage 1 dropped during stall");
`endif

endmodule

>>> bench/fixed_point_alu_top_tb.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_top_tb
// Drives fixed-point operations through the ALU with random bursts and
// output stalls, predicts every result in place and checks them in order.
// ----------------------------------------------------------------------------
module fixed_point_alu_top_tb;
	import fpalu_pkg::*;

	localparam int FRAC  = DEF_FRAC_BITS;
	localparam int WIDTH = DEF_DATA_WIDTH;
	localparam int LATENCY = WIDTH + FRAC + 3;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		op_t         op;
		logic [31:0] a;
		logic [31:0] b;
	} alu_op_t;

	typedef struct {
		logic [31:0] value;
		logic        cmp;
		logic        dz;
	} alu_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	op_t operation = OP_ADD;
	logic signed [31:0] operand_a = '0;
	logic signed [31:0] operand_b = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] result_value;
	logic compare_true;
	logic divide_by_zero;

	alu_op_t pending_ops[$];
	alu_res_t expected_results[$];
	int mismatches = 0;
	int cycle_count = 0;
	bit stimulus_done = 1'b0;
	bit drain_request = 1'b0;
	bit drain_done = 1'b0;
	bit in_taken = 1'b0;
	int burst_left = 0;
	int gap_left = 0;

	fixed_point_alu_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_value(result_value), .compare_true(compare_true),
		.divide_by_zero(divide_by_zero)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// fixed-point result of one operation
	function automatic alu_res_t compute_alu(alu_op_t t);
		alu_res_t r;
		logic signed [63:0] a, b, res, q;
		a = $signed(t.a[WIDTH-1:0]);
		b = $signed(t.b[WIDTH-1:0]);
		res = '0;
		r.cmp = 1'b0;
		r.dz = 1'b0;
		case (t.op)
			OP_ADD:      res = a + b;
			OP_SUB:      res = a - b;
			OP_MUL:      res = (a * b) >>> FRAC;
			OP_DIV: begin
				if (b == 0) r.dz = 1'b1;
				else begin
					q = (a <<< FRAC) / b;
					res = q;
				end
			end
			OP_EQ:       r.cmp = (a == b);
			OP_NE:       r.cmp = (a != b);
			OP_LT:       r.cmp = (a < b);
			OP_GT:       r.cmp = (a > b);
			OP_LE:       r.cmp = (a <= b);
			OP_GE:       r.cmp = (a >= b);
			OP_MIN:      res = (a < b) ? a : b;
			OP_MAX:      res = (a > b) ? a : b;
			OP_INC:      res = a + 1;
			OP_DEC:      res = a - 1;
			OP_FROM_INT: res = a <<< FRAC;
			default:     res = a >>> FRAC;
		endcase
		r.value = 32'($signed(res[WIDTH-1:0]));
		return r;
	endfunction

	function automatic logic [31:0] random_operand();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return 32'($signed($urandom_range(0, 2047)) - 1024);
			4: return 32'($signed($urandom_range(0, 200)) - 100) <<< FRAC;
			default: return $urandom;
		endcase
	endfunction

	function automatic void add_op(op_t op, logic [31:0] a, logic [31:0] b);
		alu_op_t t;
		t.op = op;
		t.a = a;
		t.b = b;
		pending_ops.push_back(t);
	endfunction

	// stimulus
	initial begin
		alu_op_t t;
		op_t op;
		for (int k = 0; k < 16; k++) begin
			op = op_t'(k);
			add_op(op, 32'h8000_0000, 32'h7fff_ffff);
		end
		add_op(OP_DIV, 32'h0000_0500, 32'h0);
		add_op(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
		add_op(OP_DIV, 32'hffff_fd00, 32'h0000_0200);
		add_op(OP_MUL, 32'hffff_ffff, 32'h0000_0001);
		add_op(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
		add_op(OP_TO_INT, 32'hffff_ff01, 32'h0);
		add_op(OP_EQ, 32'h1234_5678, 32'h1234_5678);
		add_op(OP_INC, 32'h7fff_ffff, 32'hffff_ffff);
		add_op(OP_DEC, 32'h8000_0000, 32'h0);
		for (int n = 0; n < 1000; n++) begin
			t.op = op_t'($urandom_range(0, 15));
			t.a = random_operand();
			t.b = ($urandom_range(0, 15) == 0) ? 32'h0 : random_operand();
			if ($urandom_range(0, 7) == 0) t.b = t.a;
			pending_ops.push_back(t);
		end
	end

	// reset
	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// driver: bursts with gaps, one full drain midway
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_taken) begin
			end else if (pending_ops.size() == 420 && !drain_request && !drain_done) begin
				in_valid <= 1'b0;
				drain_request <= 1'b1;
			end else if (drain_request) begin
				in_valid <= 1'b0;
				if (expected_results.size() == 0) begin
					drain_request <= 1'b0;
					drain_done <= 1'b1;
				end
			end else if (pending_ops.size() == 0) begin
				in_valid <= 1'b0;
				stimulus_done <= 1'b1;
			end else if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else begin
				in_valid <= 1'b1;
				operation <= pending_ops[0].op;
				operand_a <= pending_ops[0].a;
				operand_b <= pending_ops[0].b;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
			// stall pattern on the result side
			if (cycle_count % 300 < 100) out_ready <= 1'b1;
			else out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// accepted transactions on the input: predict and pop
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		in_taken <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			expected_results.push_back(compute_alu(pending_ops[0]));
			void'(pending_ops.pop_front());
		end
	end

	// monitor: compare each result with the oldest prediction
	always @(posedge clk) begin
		alu_res_t e;
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result with no transaction waiting");
				mismatches++;
			end else begin
				e = expected_results.pop_front();
				if (result_value !== e.value) begin
					$error("result_value expected %h actual %h", e.value, result_value);
					mismatches++;
				end
				if (compare_true !== e.cmp) begin
					$error("compare_true expected %b actual %b", e.cmp, compare_true);
					mismatches++;
				end
				if (divide_by_zero !== e.dz) begin
					$error("divide_by_zero expected %b actual %b", e.dz, divide_by_zero);
					mismatches++;
				end
			end
		end
	end

	// end of run and timeout
	initial begin
		fork
			begin
				wait (stimulus_done && expected_results.size() == 0);
				repeat (LATENCY + 10) @(posedge clk);
				if (mismatches == 0 && expected_results.size() == 0)
					$display("No mismatches found");
				else
					$display("Mismatches found");
			end
			begin
				wait (cycle_count >= CYCLE_LIMIT);
				$display("Mismatches found");
			end
		join_any
		$finish;
	end

endmodule

>>> sim.f
rtl/core/fpalu_pkg.sv
rtl/core/fixed_point_alu_top.sv
bench/fixed_point_alu_top_tb.sv
